/* rtl/core/rte_pkg.sv */
package rte_pkg;

    // width of every time value in ms
    localparam int unsigned TIME_BITS = 18;
    localparam int unsigned CFG_DATA_BITS = 18;
    localparam int unsigned RETRY_BITS = 3;
    localparam int unsigned CFG_INDEX_BITS = 2;

    // event kinds
    localparam logic OP_ACK     = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_TIMEOUT     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_TIMEOUT     = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RETRY_LIMIT     = 2'd3;

    // register reset values
    localparam logic [TIME_BITS-1:0]  INITIAL_TIMEOUT_RST = TIME_BITS'(3000);
    localparam logic [TIME_BITS-1:0]  MAX_TIMEOUT_RST     = TIME_BITS'(240000);
    localparam logic [TIME_BITS-1:0]  MIN_TIMEOUT_RST     = TIME_BITS'(1000);
    localparam logic [RETRY_BITS-1:0] RETRY_LIMIT_RST     = RETRY_BITS'(5);
    localparam logic [RETRY_BITS-1:0] RETRY_MAX           = '1;

    typedef struct packed {
        logic [TIME_BITS-1:0]  initial_timeout_ms;
        logic [TIME_BITS-1:0]  max_timeout_ms;
        logic [TIME_BITS-1:0]  min_timeout_ms;
        logic [RETRY_BITS-1:0] retry_limit;
    } cfg_t;

    // load of the running timeout on a write of the initial timeout
    typedef struct packed {
        logic                 load;
        logic [TIME_BITS-1:0] value;
    } init_load_t;

    typedef struct packed {
        logic                 op;
        logic [TIME_BITS-1:0] sample_ms;
    } event_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]  timeout_ms;
        logic                  resend;
        logic                  give_up;
        logic [RETRY_BITS-1:0] retry_count;
    } result_t;

    // a timeout never reads as zero
    function automatic logic [TIME_BITS-1:0] floor_one(input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS-1:0] r;
        r = (t == '0) ? TIME_BITS'(1) : t;
        return r;
    endfunction

endpackage

/* rtl/core/rte_cfg_regs.sv */
module rte_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rte_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rte_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output rte_pkg::cfg_t                     cfg,
    output rte_pkg::init_load_t               init_load
);

    rte_pkg::cfg_t cfg_reg;
    rte_pkg::cfg_t cfg_next;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                rte_pkg::REG_INITIAL_TIMEOUT: begin
                    cfg_next.initial_timeout_ms = cfg_data[rte_pkg::TIME_BITS-1:0];
                end
                rte_pkg::REG_MAX_TIMEOUT: begin
                    cfg_next.max_timeout_ms = cfg_data[rte_pkg::TIME_BITS-1:0];
                end
                rte_pkg::REG_MIN_TIMEOUT: begin
                    cfg_next.min_timeout_ms = cfg_data[rte_pkg::TIME_BITS-1:0];
                end
                rte_pkg::REG_RETRY_LIMIT: begin
                    cfg_next.retry_limit = cfg_data[rte_pkg::RETRY_BITS-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_timeout_ms <= rte_pkg::INITIAL_TIMEOUT_RST;
            cfg_reg.max_timeout_ms     <= rte_pkg::MAX_TIMEOUT_RST;
            cfg_reg.min_timeout_ms     <= rte_pkg::MIN_TIMEOUT_RST;
            cfg_reg.retry_limit        <= rte_pkg::RETRY_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // new initial timeout, passed on to the estimator in the write cycle
    assign init_load.load  = cfg_wr_en && (cfg_index == rte_pkg::REG_INITIAL_TIMEOUT);
    assign init_load.value = rte_pkg::floor_one(cfg_data[rte_pkg::TIME_BITS-1:0]);

    assign cfg = cfg_reg;

endmodule

/* rtl/core/rte_estimator.sv */
module rte_estimator (
    input  logic                aclk,
    input  logic                aresetn,
    input  rte_pkg::cfg_t       cfg,
    input  rte_pkg::init_load_t init_load,
    input  logic                fire,
    input  rte_pkg::event_t     ev,
    output rte_pkg::result_t    res
);

    localparam int unsigned TB = rte_pkg::TIME_BITS;
    localparam int unsigned RB = rte_pkg::RETRY_BITS;

    logic [TB-1:0] srtt_reg, srtt_next;
    logic [TB-1:0] dev_reg, dev_next;
    logic [TB-1:0] cur_to_reg, cur_to_next;
    logic [RB-1:0] retries_reg, retries_next;
    logic          have_sample_reg, have_sample_next;

    logic [TB+2:0] avg_sum;
    logic [TB-1:0] srtt_upd;
    logic [TB-1:0] diff;
    logic [TB+1:0] dev_sum;
    logic [TB-1:0] dev_upd;
    logic [TB-1:0] srtt_new;
    logic [TB-1:0] dev_new;
    logic [TB+2:0] rto_raw;
    logic [TB+2:0] rto_min;
    logic [TB-1:0] rto_new;
    logic [TB:0]   dbl;
    logic [TB-1:0] backoff;
    logic [RB-1:0] ret_inc;
    logic          limit_hit;
    logic          resend;
    logic          give_up;

    // smoothed rtt: (7*srtt + s) >> 3
    assign avg_sum  = {srtt_reg, 3'b000} - {3'b000, srtt_reg} + {3'b000, ev.sample_ms};
    assign srtt_upd = avg_sum[TB+2:3];

    // deviation: (3*dev + |s - srtt'|) >> 2
    assign diff     = (ev.sample_ms >= srtt_upd) ? (ev.sample_ms - srtt_upd)
                                                 : (srtt_upd - ev.sample_ms);
    assign dev_sum  = {1'b0, dev_reg, 1'b0} + {2'b00, dev_reg} + {2'b00, diff};
    assign dev_upd  = dev_sum[TB+1:2];

    // first sample seeds the estimator
    assign srtt_new = have_sample_reg ? srtt_upd : ev.sample_ms;
    assign dev_new  = have_sample_reg ? dev_upd  : {1'b0, ev.sample_ms[TB-1:1]};

    // rto = srtt + 4*dev, min clamp, then max clamp, never zero
    assign rto_raw  = {3'b000, srtt_new} + {1'b0, dev_new, 2'b00};
    assign rto_min  = (rto_raw < {3'b000, cfg.min_timeout_ms})
                      ? {3'b000, cfg.min_timeout_ms} : rto_raw;
    assign rto_new  = rte_pkg::floor_one((rto_min > {3'b000, cfg.max_timeout_ms})
                      ? cfg.max_timeout_ms : rto_min[TB-1:0]);

    // backoff doubling, saturating at the maximum
    assign dbl      = {cur_to_reg, 1'b0};
    assign backoff  = rte_pkg::floor_one((dbl > {1'b0, cfg.max_timeout_ms})
                      ? cfg.max_timeout_ms : dbl[TB-1:0]);

    // retry counting saturates at its top value
    assign ret_inc   = (retries_reg == rte_pkg::RETRY_MAX) ? retries_reg
                                                            : retries_reg + RB'(1);
    assign limit_hit = (ret_inc >= cfg.retry_limit);

    // next state for one item, or for a load of the initial timeout before the first sample
    always_comb begin
        srtt_next        = srtt_reg;
        dev_next         = dev_reg;
        cur_to_next      = cur_to_reg;
        retries_next     = retries_reg;
        have_sample_next = have_sample_reg;
        resend           = 1'b0;
        give_up          = 1'b0;
        if (fire) begin
            unique case (ev.op)
                rte_pkg::OP_ACK: begin
                    // only an unretried ack feeds the estimator
                    if (retries_reg == '0) begin
                        srtt_next        = srtt_new;
                        dev_next         = dev_new;
                        cur_to_next      = rto_new;
                        have_sample_next = 1'b1;
                    end
                    retries_next = '0;
                end
                rte_pkg::OP_TIMEOUT: begin
                    retries_next = ret_inc;
                    if (limit_hit) begin
                        give_up = 1'b1;
                    end else begin
                        resend      = 1'b1;
                        cur_to_next = backoff;
                    end
                end
                default: begin
                    retries_next = retries_reg;
                end
            endcase
        end else if (init_load.load && !have_sample_reg) begin
            cur_to_next = init_load.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srtt_reg        <= '0;
            dev_reg         <= '0;
            cur_to_reg      <= rte_pkg::INITIAL_TIMEOUT_RST;
            retries_reg     <= '0;
            have_sample_reg <= 1'b0;
        end else begin
            srtt_reg        <= srtt_next;
            dev_reg         <= dev_next;
            cur_to_reg      <= cur_to_next;
            retries_reg     <= retries_next;
            have_sample_reg <= have_sample_next;
        end
    end

    assign res.timeout_ms  = cur_to_next;
    assign res.resend      = resend;
    assign res.give_up     = give_up;
    assign res.retry_count = retries_next;

endmodule

/* rtl/core/retransmit_timeout_estimator_top.sv */
// an accepted item waits in the input register and moves to the result register when it fires
// throughput: one item per cycle while results are taken on m_ready
// while a result waits on m_ready the input register holds one more item, then
// s_ready drops until the result is taken
// reset (aresetn low, synchronous): registers to their defaults, timeout to the
// initial value, estimator and retry count cleared, both valids low
module retransmit_timeout_estimator_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rte_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rte_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_op,
    input  logic [rte_pkg::TIME_BITS-1:0]      s_sample_ms,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rte_pkg::TIME_BITS-1:0]      m_timeout_ms,
    output logic                               m_resend,
    output logic                               m_give_up,
    output logic [rte_pkg::RETRY_BITS-1:0]     m_retry_count
);

    rte_pkg::cfg_t       cfg;
    rte_pkg::init_load_t init_load;
    rte_pkg::event_t     ev_reg, ev_next;
    rte_pkg::result_t    res;
    rte_pkg::result_t    out_reg, out_next;
    logic                in_valid_reg, in_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                fire;

    rte_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .init_load (init_load)
    );

    // item moves from input register to result register
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    rte_estimator u_est (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .init_load (init_load),
        .fire      (fire),
        .ev        (ev_reg),
        .res       (res)
    );

    // input register
    always_comb begin
        ev_next.op        = s_op;
        ev_next.sample_ms = s_sample_ms;
        in_valid_next     = (s_valid && s_ready) || (in_valid_reg && !fire);
    end

    // result register
    always_comb begin
        out_next       = fire ? res : out_reg;
        out_valid_next = fire || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ev_reg <= ev_next;
        end
        out_reg <= out_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_timeout_ms  = out_reg.timeout_ms;
    assign m_resend      = out_reg.resend;
    assign m_give_up     = out_reg.give_up;
    assign m_retry_count = out_reg.retry_count;

endmodule

/* rtl/core/rte_checker.sv */
module rte_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [rte_pkg::TIME_BITS-1:0]      m_timeout_ms,
    input logic                               m_resend,
    input logic                               m_give_up,
    input logic [rte_pkg::RETRY_BITS-1:0]     m_retry_count
);

    // resend and give-up exclude each other
    a_resend_xor_give_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_resend && m_give_up))
        else $error("resend and give_up both set");

    // resend or give-up only follow a counted retry
    a_retry_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_resend || m_give_up)) |-> (m_retry_count != '0))
        else $error("timeout outcome with zero retry count");

    // a timeout is never reported as zero
    a_timeout_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_timeout_ms != '0))
        else $error("zero timeout reported");

    // a stalled result stays put until it is taken
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid &&
            $stable({m_timeout_ms, m_resend, m_give_up, m_retry_count})))
        else $error("result changed while stalled");

    // no result straight out of reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind retransmit_timeout_estimator_top rte_checker u_rte_checker (.*);
